[design/spsl_pkg.sv]
package spsl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_APPEND,
        OP_SORT_START,
        OP_SORT_LOAD,
        OP_SORT_SHIFT,
        OP_SORT_PLACE,
        OP_SORT_PUT0,
        OP_SRCH_START,
        OP_PROBE_ISSUE,
        OP_PROBE_STEP,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    set_status;
        status_t new_status;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic full;
        logic sorted;
        logic small_table;
        logic w_gt_v;
        logic j_one;
        logic more_i;
        logic range_empty;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

[design/sorted_pointer_set_lookup.sv]
// Lazily sorted key table with binary-search lookup. Each input beat is
// either an append (s_kind 0) or a query (s_kind 1) of a 64-bit unsigned key,
// and each produces exactly one result beat. An append answers stored, or
// table full when 256 keys are already held (the key is then dropped). A
// query on a sorted table runs a binary search of P probes (at most 9 for
// 256 keys): each probe is one read of the single-port-read key memory
// plus a compare. The first query after a stored append, once two or more
// keys are held, first runs an insertion sort over the stored keys in that
// same memory, loading each key and shifting larger keys up one position
// at a time until it is placed. One item is in work at a time; the result
// sits in an output register, so the next beat can be taken while the
// previous result waits on m_ready. Found answers carry the key; every
// other status carries zero.
module sorted_pointer_set_lookup
    import spsl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_kind,
    input  logic [KEY_W-1:0] s_key_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [KEY_W-1:0] m_match_value
);

    cmd_t  cmd;
    stat_t stat;

    // Controller: sequences append, sort passes, probes and result hand-off
    spsl_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // Datapath: key memory, count, sorted flag, sort and search registers
    spsl_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_kind       (s_kind),
        .s_key_value  (s_key_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_match_value(m_match_value),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

[design/spsl_ram.sv]
module spsl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/spsl_ctrl.sv]
module spsl_ctrl
    import spsl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DISPATCH  = 9'b000000010,
        S_SORT_LOAD = 9'b000000100,
        S_SORT_CMP  = 9'b000001000,
        S_SORT_PUT0 = 9'b000010000,
        S_SRCH_INIT = 9'b000100000,
        S_SEARCH    = 9'b001000000,
        S_PROBE     = 9'b010000000,
        S_FINISH    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.set_status = 1'b0;
        cmd.new_status = ST_STORED;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_TAKE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!stat.is_query) begin
                    cmd.set_status = 1'b1;
                    if (stat.full) begin
                        cmd.new_status = ST_FULL;
                    end else begin
                        cmd.op         = OP_APPEND;
                        cmd.new_status = ST_STORED;
                    end
                    state_next = S_FINISH;
                end else if (stat.sorted || stat.small_table) begin
                    state_next = S_SRCH_INIT;
                end else begin
                    cmd.op     = OP_SORT_START;
                    state_next = S_SORT_LOAD;
                end
            end
            S_SORT_LOAD: begin
                cmd.op     = OP_SORT_LOAD;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (stat.w_gt_v) begin
                    cmd.op     = OP_SORT_SHIFT;
                    state_next = stat.j_one ? S_SORT_PUT0 : S_SORT_CMP;
                end else begin
                    cmd.op     = OP_SORT_PLACE;
                    state_next = stat.more_i ? S_SORT_LOAD : S_SRCH_INIT;
                end
            end
            S_SORT_PUT0: begin
                cmd.op     = OP_SORT_PUT0;
                state_next = stat.more_i ? S_SORT_LOAD : S_SRCH_INIT;
            end
            S_SRCH_INIT: begin
                cmd.op     = OP_SRCH_START;
                state_next = S_SEARCH;
            end
            S_SEARCH: begin
                if (stat.range_empty) begin
                    cmd.set_status = 1'b1;
                    cmd.new_status = ST_MISSING;
                    state_next     = S_FINISH;
                end else begin
                    cmd.op     = OP_PROBE_ISSUE;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (stat.hit) begin
                    cmd.set_status = 1'b1;
                    cmd.new_status = ST_FOUND;
                    state_next     = S_FINISH;
                end else begin
                    cmd.op     = OP_PROBE_STEP;
                    state_next = S_SEARCH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.op     = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/spsl_dp.sv]
module spsl_dp
    import spsl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_kind,
    input  logic [KEY_W-1:0] s_key_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [KEY_W-1:0] m_match_value,
    input  cmd_t             cmd,
    output stat_t            stat
);

    logic             kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] count_reg;
    logic             sorted_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [KEY_W-1:0] v_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid_reg;
    status_t          pend_reg;
    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [KEY_W-1:0] m_match_reg;

    logic             ram_we;
    logic [CNT_W-1:0] waddr_full;
    logic [KEY_W-1:0] ram_wdata;
    logic [CNT_W-1:0] raddr_full;
    logic [KEY_W-1:0] ram_rdata;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] i_inc;

    spsl_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(waddr_full[ADDR_W-1:0]),
        .wdata(ram_wdata),
        .raddr(raddr_full[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign i_inc = i_reg + CNT_W'(1);

    // Memory port steering per operation
    always_comb begin
        ram_we     = 1'b0;
        waddr_full = count_reg;
        ram_wdata  = key_reg;
        raddr_full = mid;
        unique case (cmd.op)
            OP_APPEND: begin
                ram_we = 1'b1;
            end
            OP_SORT_START: begin
                raddr_full = CNT_W'(1);
            end
            OP_SORT_LOAD: begin
                raddr_full = i_reg - CNT_W'(1);
            end
            OP_SORT_SHIFT: begin
                ram_we     = 1'b1;
                waddr_full = j_reg;
                ram_wdata  = ram_rdata;
                raddr_full = j_reg - CNT_W'(2);
            end
            OP_SORT_PLACE: begin
                ram_we     = 1'b1;
                waddr_full = j_reg;
                ram_wdata  = v_reg;
                raddr_full = i_inc;
            end
            OP_SORT_PUT0: begin
                ram_we     = 1'b1;
                waddr_full = '0;
                ram_wdata  = v_reg;
                raddr_full = i_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sorted_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (cmd.op != OP_LOAD_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_APPEND: begin
                    count_reg  <= count_reg + CNT_W'(1);
                    sorted_reg <= 1'b0;
                end
                OP_SRCH_START: begin
                    sorted_reg <= 1'b1;
                end
                OP_LOAD_OUT: begin
                    m_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_status) begin
            pend_reg <= cmd.new_status;
        end
        unique case (cmd.op)
            OP_TAKE: begin
                kind_reg <= s_kind;
                key_reg  <= s_key_value;
            end
            OP_SORT_START: begin
                i_reg <= CNT_W'(1);
            end
            OP_SORT_LOAD: begin
                v_reg <= ram_rdata;
                j_reg <= i_reg;
            end
            OP_SORT_SHIFT: begin
                j_reg <= j_reg - CNT_W'(1);
            end
            OP_SORT_PLACE, OP_SORT_PUT0: begin
                i_reg <= i_inc;
            end
            OP_SRCH_START: begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            OP_PROBE_ISSUE: begin
                mid_reg <= mid;
            end
            OP_PROBE_STEP: begin
                if (ram_rdata < key_reg) begin
                    lo_reg <= mid_reg + CNT_W'(1);
                end else begin
                    hi_reg <= mid_reg;
                end
            end
            OP_LOAD_OUT: begin
                m_status_reg <= pend_reg;
                m_match_reg  <= (pend_reg == ST_FOUND) ? key_reg : '0;
            end
            default: begin
            end
        endcase
    end

    assign stat.is_query    = (kind_reg == KIND_QUERY);
    assign stat.full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.sorted      = sorted_reg;
    assign stat.small_table = (count_reg < CNT_W'(2));
    assign stat.w_gt_v      = (ram_rdata > v_reg);
    assign stat.j_one       = (j_reg == CNT_W'(1));
    assign stat.more_i      = (i_inc < count_reg);
    assign stat.range_empty = (lo_reg >= hi_reg);
    assign stat.hit         = (ram_rdata == key_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_match_value = m_match_reg;

endmodule

[design/spsl_checker.sv]
module spsl_checker
    import spsl_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_status,
    input logic [KEY_W-1:0] m_match_value
);

    logic [1:0] pend_reg;
    logic       s_beat;
    logic       m_beat;

    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid && m_ready;

    // Count accepted beats that still owe their result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else if (s_beat && !m_beat) begin
            pend_reg <= pend_reg + 2'd1;
        end else if (m_beat && !s_beat) begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_match_value))
        else $error("result beat changed while stalled");

    a_zero_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_FOUND) |-> m_match_value == '0)
        else $error("nonzero match value on a non-found result");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_ready)
        else $error("second beat taken while one is in work");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> (pend_reg != 2'd0))
        else $error("result beat without an accepted input beat");

endmodule

bind sorted_pointer_set_lookup spsl_checker u_spsl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_match_value(m_match_value)
);

[dv/tb_sorted_pointer_set_lookup.sv]
`timescale 1ns / 1ps

module tb_sorted_pointer_set_lookup;
    import spsl_pkg::*;

    // Longest stretch without any beat on either channel. It must outlast
    // the sort that a query runs after a full table of reversed appends.
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    // Length of the long receiver hold-off in the backpressure test.
    localparam int unsigned HOLD_CYCLES    = 600;

    typedef struct {
        logic             kind;
        logic [KEY_W-1:0] key;
    } lookup_req_t;

    typedef struct {
        status_t          status;
        logic [KEY_W-1:0] match;
    } lookup_ans_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_kind;
    logic [KEY_W-1:0] s_key_value;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_status;
    logic [KEY_W-1:0] m_match_value;

    // Shadow copy of the key table, its fill count and its sorted flag.
    logic [KEY_W-1:0] key_shadow [TABLE_DEPTH];
    int unsigned      keys_held    = 0;
    bit               table_sorted = 1'b1;

    lookup_req_t      req_fifo[$];
    lookup_ans_t      pending_answers[$];

    int unsigned queued_total  = 0;
    int unsigned offered_total = 0;
    int unsigned in_beats      = 0;
    int unsigned out_beats     = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_tickets  = 0;
    int unsigned idle_cycles   = 0;
    int unsigned error_count   = 0;
    int unsigned cnt_stored    = 0;
    int unsigned cnt_full      = 0;
    int unsigned cnt_found     = 0;
    int unsigned cnt_missing   = 0;

    sorted_pointer_set_lookup u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key_value   (s_key_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_match_value (m_match_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Compute the answer to one accepted beat and advance the shadow state.
    // Appends go to the end and clear the sorted flag; a full table drops the
    // key and leaves the flag alone. A query sorts lazily (insertion sort,
    // unsigned order) and then binary-searches the stored keys.
    function automatic lookup_ans_t lookup_predict(input logic kind,
                                                   input logic [KEY_W-1:0] key);
        lookup_ans_t      ans;
        logic [KEY_W-1:0] v;
        int unsigned      i;
        int unsigned      j;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        bit               hit;
        ans.status = ST_MISSING;
        ans.match  = '0;
        if (kind == KIND_APPEND) begin
            if (keys_held < TABLE_DEPTH) begin
                key_shadow[keys_held] = key;
                keys_held++;
                table_sorted = 1'b0;
                ans.status = ST_STORED;
            end else begin
                ans.status = ST_FULL;
            end
        end else begin
            if (!table_sorted) begin
                for (i = 1; i < keys_held; i++) begin
                    v = key_shadow[i];
                    j = i;
                    while (j > 0 && key_shadow[j-1] > v) begin
                        key_shadow[j] = key_shadow[j-1];
                        j--;
                    end
                    key_shadow[j] = v;
                end
                table_sorted = 1'b1;
            end
            lo  = 0;
            hi  = keys_held;
            hit = 1'b0;
            while (lo < hi && !hit) begin
                mid = lo + (hi - lo) / 2;
                if (key_shadow[mid] == key) begin
                    hit = 1'b1;
                end else if (key_shadow[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            if (hit) begin
                ans.status = ST_FOUND;
                ans.match  = key;
            end
        end
        return ans;
    endfunction

    // Draw a key: stored keys and their neighbors so queries hit and just
    // miss, small values around zero, values near the top and around the
    // sign boundary (where a signed compare would go wrong), else anything.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30 && keys_held > 0) return key_shadow[$urandom_range(keys_held - 1)];
        if (r < 40 && keys_held > 0) return key_shadow[$urandom_range(keys_held - 1)] + 64'd1;
        if (r < 55) return 64'($urandom_range(15));
        if (r < 62) return {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
        if (r < 69) return {1'b1, 55'd0, 8'($urandom)};
        if (r < 76) return {1'b0, {55{1'b1}}, 8'($urandom)};
        return {$urandom, $urandom};
    endfunction

    // Input driver: change inputs on the falling edge only. Hold the beat
    // while it is outstanding; once taken, either present the next queued
    // item or drop valid, so valid gets one update per step.
    initial begin
        s_valid     = 1'b0;
        s_kind      = KIND_APPEND;
        s_key_value = '0;
        forever begin
            @(negedge aclk);
            if (offered_total == in_beats) begin
                if (req_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_kind      <= req_fifo[0].kind;
                    s_key_value <= req_fifo[0].key;
                    void'(req_fifo.pop_front());
                    offered_total++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls at the current rate, and a long hold-off of
    // HOLD_CYCLES whenever a test posts a ticket. Count the hold here.
    initial begin
        int unsigned stall_left;
        int unsigned hold_served;
        stall_left  = 0;
        hold_served = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_served != hold_tickets) begin
                hold_served++;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor on the rising edge: check each result beat against the oldest
    // expectation, then predict for any input beat taken at this edge.
    always @(posedge aclk) begin
        lookup_ans_t exp_ans;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_beats++;
                if (pending_answers.size() == 0) begin
                    $error("unexpected result beat: m_status %0d, m_match_value %h",
                           m_status, m_match_value);
                    error_count++;
                end else begin
                    exp_ans = pending_answers.pop_front();
                    case (exp_ans.status)
                        ST_STORED:  cnt_stored++;
                        ST_FULL:    cnt_full++;
                        ST_FOUND:   cnt_found++;
                        ST_MISSING: cnt_missing++;
                        default:    ;
                    endcase
                    if (m_status !== exp_ans.status) begin
                        $error("m_status: expected %0d, got %0d", exp_ans.status, m_status);
                        error_count++;
                    end
                    if (m_match_value !== exp_ans.match) begin
                        $error("m_match_value: expected %h, got %h",
                               exp_ans.match, m_match_value);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_answers.push_back(lookup_predict(s_kind, s_key_value));
                in_beats++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    // Queue one item and block until the block takes it.
    task automatic send_item(input logic kind, input logic [KEY_W-1:0] key);
        int unsigned ticket;
        lookup_req_t req;
        req.kind = kind;
        req.key  = key;
        ticket   = queued_total;
        queued_total++;
        req_fifo.push_back(req);
        while (in_beats <= ticket) @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // Queries on a table that has never held a key.
    task automatic test_empty_table();
        send_item(KIND_QUERY, '0);
        send_item(KIND_QUERY, '1);
        wait_drained();
    endtask

    // Keys on both sides of the sign bit: order must be unsigned.
    task automatic test_unsigned_order();
        send_item(KIND_APPEND, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_APPEND, 64'h8000_0000_0000_0000);
        send_item(KIND_APPEND, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_APPEND, 64'h0000_0000_0000_0001);
        send_item(KIND_QUERY,  64'h8000_0000_0000_0000);
        send_item(KIND_QUERY,  64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_QUERY,  64'h0000_0000_0000_0001);
        send_item(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFE);
        send_item(KIND_QUERY,  64'h8000_0000_0000_0001);
        wait_drained();
    endtask

    // Key zero absent then present (found with a zero match), and a
    // duplicate key kept alongside alternating bit patterns.
    task automatic test_zero_and_duplicates();
        send_item(KIND_QUERY,  '0);
        send_item(KIND_APPEND, '0);
        send_item(KIND_QUERY,  '0);
        send_item(KIND_APPEND, 64'h0000_0000_0000_0001);
        send_item(KIND_APPEND, 64'h5555_5555_5555_5555);
        send_item(KIND_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_QUERY,  64'h0000_0000_0000_0001);
        send_item(KIND_QUERY,  64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_QUERY,  64'h5555_5555_5555_5555);
        wait_drained();
    endtask

    // Bursts of appends and bursts of queries, so sorts run over tables
    // with fresh keys at the end and searches run on sorted tables.
    task automatic test_random_mix(input int unsigned n_items, input int unsigned append_pct);
        int unsigned sent;
        int unsigned run_len;
        int unsigned k;
        logic        kind;
        sent = 0;
        while (sent < n_items) begin
            kind    = ($urandom_range(99) < append_pct) ? KIND_APPEND : KIND_QUERY;
            run_len = $urandom_range(1, 6);
            for (k = 0; k < run_len && sent < n_items; k++) begin
                send_item(kind, pick_key());
                sent++;
            end
        end
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so
    // the output register and the work slot fill and s_ready drops.
    task automatic test_backpressure();
        int unsigned k;
        hold_tickets++;
        for (k = 0; k < 8; k++) begin
            send_item(k[0] ? KIND_QUERY : KIND_APPEND, pick_key());
        end
        wait_drained();
    endtask

    // Fill the table with descending keys (a long insertion sort), then
    // append into a full table and query after it.
    task automatic test_full_table();
        logic [KEY_W-1:0] key;
        key = 64'hFFFF_FFFF_FFFF_FF00;
        while (keys_held < TABLE_DEPTH) begin
            send_item(KIND_APPEND, key);
            key = key - 64'd3;
        end
        send_item(KIND_APPEND, '1);
        send_item(KIND_APPEND, '0);
        send_item(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FF00);
        send_item(KIND_QUERY,  '0);
        send_item(KIND_QUERY,  key + 64'd3);
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Sender idles lightly, receiver idles heavily.
        send_idle_pct = 20;
        recv_idle_pct = 84;
        test_empty_table();
        test_unsigned_order();
        test_zero_and_duplicates();
        test_random_mix(330, 45);
        test_backpressure();

        // Swap the idle rates.
        send_idle_pct = 84;
        recv_idle_pct = 20;
        test_random_mix(100, 50);
        test_full_table();
        test_random_mix(250, 30);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(320, 30);

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Run: %0d beats in, %0d out; stored %0d, full %0d, found %0d, not found %0d",
                 in_beats, out_beats, cnt_stored, cnt_full, cnt_found, cnt_missing);
        $display("Covered empty and full table, unsigned extremes, zero key, duplicates, stalls");
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
